// File: src/ivba_pkg.sv
// shared types and constants for the interrupt vector block allocator
package ivba_pkg;

    localparam int NUM_WORDS = 7;
    localparam int WORD_BITS = 32;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LOG_W     = 3;

    localparam logic [7:0] VEC_FIRST = 8'h20;
    localparam logic [7:0] VEC_NONE  = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_RESP
    } state_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_MARK  = 1'b1
    } req_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic fail;
    } dp_cmd_t;

    typedef struct packed {
        logic is_mark;
        logic hit;
        logic last_word;
    } dp_sts_t;

endpackage

// File: src/ivba_dp.sv
// allocation bitmap, per-word aligned run search and result registers
module ivba_dp import ivba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  logic [15:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output dp_sts_t     sts,
    output logic [7:0]  block_base,
    output logic        ok
);

    logic [WORD_BITS-1:0] map_reg [NUM_WORDS];

    req_t              req_reg, req_next;
    logic [LOG_W-1:0]  log_reg, log_next;
    logic              size_ok_reg, size_ok_next;
    logic [7:0]        vec_reg, vec_next;
    logic [WIDX_W-1:0] idx_reg, idx_next;
    logic [7:0]        base_reg, base_next;
    logic              ok_reg, ok_next;

    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] run_mask;
    logic [4:0]           align;
    logic [WORD_BITS-1:0] cand;
    logic [4:0]           hit_off;
    logic                 alloc_hit;
    logic [7:0]           alloc_base;
    logic [2:0]           mark_word;
    logic                 mark_ok;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_idx;
    logic [WORD_BITS-1:0] wr_data;
    logic [LOG_W-1:0]     dec_log;
    logic                 dec_ok;

    // block size decode
    always_comb begin
        dec_log = '0;
        dec_ok  = 1'b1;
        unique case (s_tdata[7:0])
            8'd1:    dec_log = 3'd0;
            8'd2:    dec_log = 3'd1;
            8'd4:    dec_log = 3'd2;
            8'd8:    dec_log = 3'd3;
            8'd16:   dec_log = 3'd4;
            8'd32:   dec_log = 3'd5;
            default: dec_ok  = 1'b0;
        endcase
    end

    // aligned free run search over the current word
    always_comb begin
        word     = map_reg[idx_reg];
        run_mask = ~({WORD_BITS{1'b1}} << (6'd1 << log_reg));
        align    = 5'((6'd1 << log_reg) - 6'd1);
        for (int i = 0; i < WORD_BITS; i++) begin
            cand[i] = (((word >> i) & run_mask) == '0) && ((5'(i) & align) == 5'd0);
        end
        hit_off = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit_off = 5'(i);
            end
        end
        alloc_hit  = (req_reg == REQ_ALLOC) && size_ok_reg && (|cand);
        alloc_base = VEC_FIRST + (8'(idx_reg) << 5) + 8'(hit_off);
    end

    // single vector mark decode
    always_comb begin
        mark_word = vec_reg[7:5] - 3'd1;
        mark_ok   = (vec_reg >= VEC_FIRST) && (4'(mark_word) < 4'(NUM_WORDS));
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = word | (run_mask << hit_off);
        if (cmd.commit) begin
            if (req_reg == REQ_MARK) begin
                wr_en   = mark_ok;
                wr_idx  = WIDX_W'(mark_word);
                wr_data = map_reg[WIDX_W'(mark_word)] | (32'd1 << vec_reg[4:0]);
            end else begin
                wr_en = alloc_hit;
            end
        end
    end

    always_comb begin
        req_next     = req_reg;
        log_next     = log_reg;
        size_ok_next = size_ok_reg;
        vec_next     = vec_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        ok_next      = ok_reg;
        if (cmd.load) begin
            req_next     = req_t'(s_tuser[0]);
            log_next     = dec_log;
            size_ok_next = dec_ok;
            vec_next     = s_tdata[15:8];
            idx_next     = '0;
        end
        if (cmd.step) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.commit) begin
            if (req_reg == REQ_MARK) begin
                base_next = VEC_NONE;
                ok_next   = mark_ok;
            end else begin
                base_next = alloc_base;
                ok_next   = 1'b1;
            end
        end
        if (cmd.fail) begin
            base_next = VEC_NONE;
            ok_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else if (wr_en) begin
            map_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        log_reg     <= log_next;
        size_ok_reg <= size_ok_next;
        vec_reg     <= vec_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        ok_reg      <= ok_next;
    end

    assign sts.is_mark   = (req_reg == REQ_MARK);
    assign sts.hit       = alloc_hit;
    assign sts.last_word = (idx_reg == WIDX_W'(NUM_WORDS - 1)) || !size_ok_reg;
    assign block_base    = base_reg;
    assign ok            = ok_reg;

endmodule

// File: src/ivba_ctrl.sv
// request sequencer for the vector allocator
module ivba_ctrl import ivba_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WORK;
                end
            end
            ST_WORK: begin
                if (sts.is_mark || sts.hit) begin
                    cmd.commit = 1'b1;
                    state_next = ST_RESP;
                end else if (sts.last_word) begin
                    cmd.fail   = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_WORK))
        else $error("accepted word did not start work");
    a_hit_responds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WORK && sts.hit) |=> (state_reg == ST_RESP))
        else $error("hit did not lead to response");
    a_scan_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WORK && !sts.is_mark && !sts.hit && !sts.last_word)
        |=> (state_reg == ST_WORK))
        else $error("scan stopped early");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while result pending");
`endif

endmodule

// File: src/interrupt_vector_block_allocator.sv
// top level of the interrupt vector block allocator
//
// channel  | tdata                                  | tuser
// s_ input | [7:0] block_count, [15:8] vector       | [0] req_type
// m_ out   | [7:0] block_base                       | [0] ok
//
// one word at a time: an accept state, then a scan of the bitmap (one bitmap word per cycle),
// then the result is held until taken
// a mark request commits in the work state without scanning the bitmap
// aresetn clears the bitmap and the controller at once, no clearing pass
// no new word is taken while a result waits on m_tready
module interrupt_vector_block_allocator import ivba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // block_count, vector
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // block_base
    output logic [0:0]  m_tuser    // ok
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    ok;

    ivba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ivba_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .sts        (sts),
        .block_base (m_tdata),
        .ok         (ok)
    );

    assign m_tuser[0] = ok;

endmodule
